// File: design/svb_pkg.sv
package svb_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 24;
   localparam int RHO_W      = FRAC_BITS + 2;

   // internal arithmetic: 64-bit signed, saturating at +/-(2^62-1)
   localparam int IW = 64;
   localparam int PW = 2 * IW;
   localparam int MW = IW - 2;

   localparam int MUL_STEPS  = IW;
   localparam int DIV_STEPS  = IW + FRAC_BITS;
   localparam int SQRT_STEPS = IW;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam logic signed [IW-1:0] WIDE_LIM = {2'b00, {MW{1'b1}}};
   localparam logic signed [IW-1:0] ONE_Q =
      {{(IW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [IW-1:0] QUARTER_Q = ONE_Q >>> 2;
   localparam logic signed [IW-1:0] OUT_MAX =
      {{(IW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [IW-1:0] OUT_MIN =
      {{(IW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   localparam logic [DATA_WIDTH-2:0] SLOPE_B_RESET =
      (DATA_WIDTH-1)'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic [DATA_WIDTH-2:0] SIGMA_RESET =
      (DATA_WIDTH-1)'(((1 << FRAC_BITS) + 10) / 20);

   // configuration register indexes
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] REG_LEVEL_A   = 3'd0;
   localparam logic [CSR_IW-1:0] REG_SLOPE_B   = 3'd1;
   localparam logic [CSR_IW-1:0] REG_SKEW_RHO  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_SHIFT_M   = 3'd3;
   localparam logic [CSR_IW-1:0] REG_SIGMA     = 3'd4;
   localparam logic [CSR_IW-1:0] REG_TOLERANCE = 3'd5;

   // arithmetic unit operations
   localparam logic [1:0] OP_FMUL = 2'd0;  // fixed-point product, saturated
   localparam logic [1:0] OP_MULW = 2'd1;  // full 128-bit product of magnitudes
   localparam logic [1:0] OP_FDIV = 2'd2;  // fixed-point quotient, saturated
   localparam logic [1:0] OP_SQRT = 2'd3;  // floor square root of 128-bit radicand

   typedef struct packed {
      logic                 start;
      logic [1:0]           op;
      logic signed [IW-1:0] opa;
      logic signed [IW-1:0] opb;
      logic [PW-1:0]        rad;
   } svb_mdu_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [IW-1:0] res;
      logic [PW-1:0]        prod;
   } svb_mdu_rsp_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] worst;
      logic signed [DATA_WIDTH-1:0] point;
      logic                         free;
   } svb_sweep_type;

   function automatic logic signed [IW+1:0] wx(input logic signed [IW-1:0] v);
      return {{2{v[IW-1]}}, v};
   endfunction

   function automatic logic signed [IW-1:0] sat_sum(input logic signed [IW+1:0] v);
      logic signed [IW+1:0] lim;
      lim = {2'b00, WIDE_LIM};
      if (v > lim) begin
         return WIDE_LIM;
      end else if (v < -lim) begin
         return -WIDE_LIM;
      end
      return v[IW-1:0];
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] clamp_out(
      input logic signed [IW-1:0] v);
      if (v > OUT_MAX) begin
         return OUT_MAX[DATA_WIDTH-1:0];
      end else if (v < OUT_MIN) begin
         return OUT_MIN[DATA_WIDTH-1:0];
      end
      return v[DATA_WIDTH-1:0];
   endfunction

endpackage

// File: design/svb_mdu.sv
module svb_mdu import svb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  svb_mdu_req_type mdu_req,
   output svb_mdu_rsp_type mdu_rsp
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RUN  = 2'd1;
   localparam logic [1:0] PH_FIN  = 2'd2;

   logic [1:0]           ph_ff, ph_in;
   logic [1:0]           op_ff, op_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]        ma_ff, ma_in;    // multiplicand or divisor
   logic [IW-1:0]        hi_ff, hi_in;    // product high, remainder or root
   logic [PW-1:0]        lo_ff, lo_in;    // multiplier, numerator/quotient or radicand
   logic [IW+1:0]        rem_ff, rem_in;  // square root remainder
   logic signed [IW-1:0] res_ff, res_in;
   logic                 done_ff, done_in;

   always_comb begin
      logic [IW-1:0]   mag_a;
      logic [IW-1:0]   mag_b;
      logic [IW:0]     msum;
      logic [IW:0]     r2;
      logic [IW:0]     rdiff;
      logic            qbit;
      logic [IW+3:0]   rem2;
      logic [IW+3:0]   trial;
      logic [IW+3:0]   sdiff;
      logic [PW-1:0]   prod;
      logic [IW-1:0]   mag;
      logic [CNT_W-1:0] last_cnt;

      ph_in   = ph_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      ma_in   = ma_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      done_in = 1'b0;

      mag_a = mdu_req.opa[IW-1] ? (~mdu_req.opa + 1'b1) : mdu_req.opa;
      mag_b = mdu_req.opb[IW-1] ? (~mdu_req.opb + 1'b1) : mdu_req.opb;
      msum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, ma_ff} : {(IW+1){1'b0}});
      r2    = {hi_ff, lo_ff[PW-1]};
      rdiff = r2 - {1'b0, ma_ff};
      qbit  = (r2 >= {1'b0, ma_ff});
      rem2  = {rem_ff, lo_ff[PW-1:PW-2]};
      trial = {2'b00, hi_ff, 2'b01};
      sdiff = rem2 - trial;
      prod  = {hi_ff, lo_ff[IW-1:0]};
      last_cnt = (op_ff == OP_FDIV) ? CNT_W'(DIV_STEPS - 1) :
                 (op_ff == OP_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(MUL_STEPS - 1);

      case (op_ff)
         OP_FDIV: mag = (|lo_ff[DIV_STEPS-1:MW]) ? WIDE_LIM : {2'b00, lo_ff[MW-1:0]};
         OP_SQRT: mag = (|hi_ff[IW-1:MW]) ? WIDE_LIM : {2'b00, hi_ff[MW-1:0]};
         default: mag = (|prod[PW-1:MW+FRAC_BITS]) ? WIDE_LIM :
                        {2'b00, prod[MW+FRAC_BITS-1:FRAC_BITS]};
      endcase

      case (ph_ff)
         PH_IDLE: begin
            if (mdu_req.start) begin
               op_in  = mdu_req.op;
               cnt_in = '0;
               ph_in  = PH_RUN;
               neg_in = (mdu_req.op == OP_FMUL || mdu_req.op == OP_FDIV) &&
                        (mdu_req.opa[IW-1] != mdu_req.opb[IW-1]);
               case (mdu_req.op)
                  OP_FDIV: begin
                     ma_in = mag_b;
                     hi_in = '0;
                     lo_in = {mag_a, {(PW-IW){1'b0}}};
                     // zero divisor: 0/0 gives 0, anything else saturates
                     if (mag_b == '0) begin
                        lo_in = (mag_a == '0) ? '0 : '1;
                        ph_in = PH_FIN;
                     end
                  end
                  OP_SQRT: begin
                     hi_in  = '0;
                     rem_in = '0;
                     lo_in  = mdu_req.rad;
                  end
                  default: begin
                     ma_in = mag_a;
                     hi_in = '0;
                     lo_in = {{IW{1'b0}}, mag_b};
                  end
               endcase
            end
         end
         PH_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            case (op_ff)
               OP_FDIV: begin
                  hi_in = qbit ? rdiff[IW-1:0] : r2[IW-1:0];
                  lo_in = {lo_ff[PW-2:0], qbit};
               end
               OP_SQRT: begin
                  if (rem2 >= trial) begin
                     rem_in = sdiff[IW+1:0];
                     hi_in  = {hi_ff[IW-2:0], 1'b1};
                  end else begin
                     rem_in = rem2[IW+1:0];
                     hi_in  = {hi_ff[IW-2:0], 1'b0};
                  end
                  lo_in = {lo_ff[PW-3:0], 2'b00};
               end
               default: begin
                  hi_in = msum[IW:1];
                  lo_in = {{IW{1'b0}}, msum[0], lo_ff[IW-1:1]};
               end
            endcase
            if (cnt_ff == last_cnt) begin
               ph_in = PH_FIN;
            end
         end
         PH_FIN: begin
            res_in  = neg_ff ? (~mag + 1'b1) : mag;
            done_in = 1'b1;
            ph_in   = PH_IDLE;
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      ma_ff  <= ma_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign mdu_rsp.done = done_ff;
   assign mdu_rsp.res  = res_ff;
   assign mdu_rsp.prod = {hi_ff, lo_ff[IW-1:0]};

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mdu_req.start |-> ph_ff == PH_IDLE)
      else $error("operation started while unit busy");

   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(ph_ff) == PH_FIN)
      else $error("done without finishing step");

   a_res_saturated: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (res_ff <= WIDE_LIM && res_ff >= -WIDE_LIM))
      else $error("result outside saturation range");

endmodule

// File: design/svb_sweep.sv
module svb_sweep import svb_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         upd,
   input  logic                         last,
   input  logic signed [DATA_WIDTH-1:0] gq,
   input  logic signed [DATA_WIDTH-1:0] kpt,
   input  logic [DATA_WIDTH-2:0]        tol,
   output svb_sweep_type                summary
);

   logic signed [DATA_WIDTH-1:0] min_ff, min_in;
   logic signed [DATA_WIDTH-1:0] pt_ff, pt_in;
   logic                         started_ff, started_in;

   logic                         take;
   logic signed [DATA_WIDTH-1:0] nmin;
   logic signed [DATA_WIDTH-1:0] npt;
   logic signed [DATA_WIDTH:0]   neg_tol;

   // ties keep the earlier point
   assign take    = !started_ff || (gq < min_ff);
   assign nmin    = take ? gq : min_ff;
   assign npt     = take ? kpt : pt_ff;
   assign neg_tol = -$signed({2'b00, tol});

   assign summary.worst = nmin;
   assign summary.point = npt;
   assign summary.free  = ($signed({nmin[DATA_WIDTH-1], nmin}) >= neg_tol);

   always_comb begin
      min_in     = min_ff;
      pt_in      = pt_ff;
      started_in = started_ff;
      if (upd) begin
         if (last) begin
            min_in     = OUT_MAX[DATA_WIDTH-1:0];
            pt_in      = '0;
            started_in = 1'b0;
         end else begin
            min_in     = nmin;
            pt_in      = npt;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= OUT_MAX[DATA_WIDTH-1:0];
         pt_ff      <= '0;
         started_ff <= 1'b0;
      end else begin
         min_ff     <= min_in;
         pt_ff      <= pt_in;
         started_ff <= started_in;
      end
   end

endmodule

// File: design/svi_smile_butterfly_check.sv
// Raw SVI butterfly (Durrleman) check. Each request carries one log-moneyness point k
// in Q8.24; the response returns w, w', w'' and the density g at that point (g = -1
// where w <= 0), all saturated to 32 bits. A request with tlast closes a sweep: its
// response has tlast set and carries the minimum g over the sweep, the first k where
// it occurred, and in tuser whether that minimum is at least -tolerance. Points are
// processed one at a time by a single bit-serial multiply/divide/square-root unit:
// a product takes 64 steps, a quotient 88 and the square root 64, each plus the start and
// finish handoff. A point with w > 0 needs 11 products, 5 quotients and one root;
// a point with w <= 0 skips the density terms. A new request is taken as soon as the
// previous response has been moved to the output register. Configuration writes are
// always accepted and take effect at once; the registers are read throughout a point,
// so write them only while no request is in progress, and they then apply from the
// next request on.
module svi_smile_butterfly_check import svb_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [DATA_WIDTH-1:0]     req_tdata,   // log_moneyness
   input  logic                      req_tlast,   // last_point
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // total_variance, variance_slope, variance_curvature, density_g,
   // worst_density, worst_point
   output logic [6*DATA_WIDTH-1:0]   rsp_tdata,
   output logic                      rsp_tlast,   // sweep_done
   output logic                      rsp_tuser,   // arbitrage_free
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IW-1:0]         csr_index,
   input  logic [DATA_WIDTH-1:0]     csr_data
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_XX   = 5'd1;
   localparam logic [4:0] S_SS   = 5'd2;
   localparam logic [4:0] S_SQ   = 5'd3;
   localparam logic [4:0] S_RX   = 5'd4;
   localparam logic [4:0] S_U    = 5'd5;
   localparam logic [4:0] S_BU   = 5'd6;
   localparam logic [4:0] S_W    = 5'd7;
   localparam logic [4:0] S_DXS  = 5'd8;
   localparam logic [4:0] S_RD   = 5'd9;
   localparam logic [4:0] S_WP   = 5'd10;
   localparam logic [4:0] S_RAT  = 5'd11;
   localparam logic [4:0] S_R2   = 5'd12;
   localparam logic [4:0] S_BR2  = 5'd13;
   localparam logic [4:0] S_WPP  = 5'd14;
   localparam logic [4:0] S_CHK  = 5'd15;
   localparam logic [4:0] S_KW   = 5'd16;
   localparam logic [4:0] S_Q1   = 5'd17;
   localparam logic [4:0] S_T1   = 5'd18;
   localparam logic [4:0] S_TT   = 5'd19;
   localparam logic [4:0] S_F    = 5'd20;
   localparam logic [4:0] S_IW   = 5'd21;
   localparam logic [4:0] S_E    = 5'd22;
   localparam logic [4:0] S_T2   = 5'd23;
   localparam logic [4:0] S_G    = 5'd24;
   localparam logic [4:0] S_OUT  = 5'd25;

   // configuration
   logic signed [DATA_WIDTH-1:0] a_ff;
   logic [DATA_WIDTH-2:0]        b_ff;
   logic signed [RHO_W-1:0]      rho_ff;
   logic signed [DATA_WIDTH-1:0] m_ff;
   logic [DATA_WIDTH-2:0]        sig_ff;
   logic [DATA_WIDTH-2:0]        tol_ff;

   // sequencer and working registers
   logic [4:0]                   st_ff, st_in;
   logic                         wait_ff, wait_in;
   logic signed [DATA_WIDTH-1:0] k_ff, k_in;
   logic                         last_ff, last_in;
   logic signed [DATA_WIDTH:0]   x_ff, x_in;
   logic [PW-1:0]                px_ff, px_in;
   logic signed [IW-1:0]         s_ff, s_in;
   logic signed [IW-1:0]         t_ff, t_in;
   logic signed [IW-1:0]         t1_ff, t1_in;
   logic signed [IW-1:0]         e_ff, e_in;
   logic signed [IW-1:0]         w_ff, w_in;
   logic signed [IW-1:0]         wp_ff, wp_in;
   logic signed [IW-1:0]         wpp_ff, wpp_in;
   logic signed [IW-1:0]         g_ff, g_in;

   // output register
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [6*DATA_WIDTH-1:0]      rsp_tdata_ff, rsp_tdata_in;
   logic                         rsp_tlast_ff, rsp_tlast_in;
   logic                         rsp_tuser_ff, rsp_tuser_in;

   logic signed [IW-1:0] a_w, b_w, rho_w, sig_w, k_w, x_w;
   logic                 is_mdu;
   logic                 out_load;
   logic signed [DATA_WIDTH-1:0] g_out;
   svb_mdu_req_type      mdu_req;
   svb_mdu_rsp_type      mdu_rsp;
   svb_sweep_type        summary;

   assign a_w   = {{(IW-DATA_WIDTH){a_ff[DATA_WIDTH-1]}}, a_ff};
   assign b_w   = {{(IW-DATA_WIDTH+1){1'b0}}, b_ff};
   assign rho_w = {{(IW-RHO_W){rho_ff[RHO_W-1]}}, rho_ff};
   assign sig_w = {{(IW-DATA_WIDTH+1){1'b0}}, sig_ff};
   assign k_w   = {{(IW-DATA_WIDTH){k_ff[DATA_WIDTH-1]}}, k_ff};
   assign x_w   = {{(IW-DATA_WIDTH-1){x_ff[DATA_WIDTH]}}, x_ff};

   assign req_tready = (st_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign out_load   = (st_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);
   assign g_out      = clamp_out(g_ff);

   // operand selection for the shared arithmetic unit
   always_comb begin
      is_mdu      = 1'b1;
      mdu_req.op  = OP_FMUL;
      mdu_req.opa = t_ff;
      mdu_req.opb = b_w;
      mdu_req.rad = px_ff;
      case (st_ff)
         S_XX: begin
            mdu_req.op  = OP_MULW;
            mdu_req.opa = x_w;
            mdu_req.opb = x_w;
         end
         S_SS: begin
            mdu_req.op  = OP_MULW;
            mdu_req.opa = sig_w;
            mdu_req.opb = sig_w;
         end
         S_SQ:  mdu_req.op = OP_SQRT;
         S_RX: begin
            mdu_req.opa = rho_w;
            mdu_req.opb = x_w;
         end
         S_BU, S_WP, S_BR2: begin
            mdu_req.opa = b_w;
            mdu_req.opb = t_ff;
         end
         S_DXS: begin
            mdu_req.op  = OP_FDIV;
            mdu_req.opa = x_w;
            mdu_req.opb = s_ff;
         end
         S_RAT: begin
            mdu_req.op  = OP_FDIV;
            mdu_req.opa = sig_w;
            mdu_req.opb = s_ff;
         end
         S_R2: begin
            mdu_req.opa = t_ff;
            mdu_req.opb = t_ff;
         end
         S_WPP: begin
            mdu_req.op  = OP_FDIV;
            mdu_req.opa = t_ff;
            mdu_req.opb = s_ff;
         end
         S_KW: begin
            mdu_req.opa = k_w;
            mdu_req.opb = wp_ff;
         end
         S_Q1: begin
            mdu_req.op  = OP_FDIV;
            mdu_req.opa = t_ff;
            mdu_req.opb = w_ff <<< 1;  // w > 0 here, so 2w fits
         end
         S_TT: begin
            mdu_req.opa = t1_ff;
            mdu_req.opb = t1_ff;
         end
         S_F: begin
            mdu_req.opa = wp_ff;
            mdu_req.opb = wp_ff;
         end
         S_IW: begin
            mdu_req.op  = OP_FDIV;
            mdu_req.opa = ONE_Q;
            mdu_req.opb = w_ff;
         end
         S_T2: begin
            mdu_req.opa = t_ff;
            mdu_req.opb = e_ff;
         end
         default: is_mdu = 1'b0;
      endcase
      mdu_req.start = is_mdu && !wait_ff;
   end

   always_comb begin
      st_in   = st_ff;
      wait_in = wait_ff;
      k_in    = k_ff;
      last_in = last_ff;
      x_in    = x_ff;
      px_in   = px_ff;
      s_in    = s_ff;
      t_in    = t_ff;
      t1_in   = t1_ff;
      e_in    = e_ff;
      w_in    = w_ff;
      wp_in   = wp_ff;
      wpp_in  = wpp_ff;
      g_in    = g_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (is_mdu) begin
         if (mdu_req.start) begin
            wait_in = 1'b1;
         end
         if (mdu_rsp.done) begin
            wait_in = 1'b0;
            st_in   = st_ff + 1'b1;
            case (st_ff)
               S_XX:    px_in  = mdu_rsp.prod;
               S_SS:    px_in  = px_ff + mdu_rsp.prod;  // x^2 + sigma^2
               S_SQ:    s_in   = mdu_rsp.res;
               S_WP:    wp_in  = mdu_rsp.res;
               S_WPP:   wpp_in = mdu_rsp.res;
               S_TT:    t1_in  = mdu_rsp.res;
               S_IW:    e_in   = mdu_rsp.res;
               default: t_in   = mdu_rsp.res;
            endcase
         end
      end else begin
         case (st_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  k_in    = req_tdata;
                  last_in = req_tlast;
                  x_in    = {req_tdata[DATA_WIDTH-1], req_tdata} - {m_ff[DATA_WIDTH-1], m_ff};
                  st_in   = S_XX;
               end
            end
            S_U: begin
               t_in  = sat_sum(wx(t_ff) + wx(s_ff));
               st_in = S_BU;
            end
            S_W: begin
               w_in  = sat_sum(wx(a_w) + wx(t_ff));
               st_in = S_DXS;
            end
            S_RD: begin
               t_in  = sat_sum(wx(rho_w) + wx(t_ff));
               st_in = S_WP;
            end
            S_CHK: begin
               if (w_ff <= 0) begin
                  g_in  = -ONE_Q;
                  st_in = S_OUT;
               end else begin
                  st_in = S_KW;
               end
            end
            S_T1: begin
               t1_in = sat_sum(wx(ONE_Q) - wx(t_ff));
               st_in = S_TT;
            end
            S_E: begin
               e_in  = sat_sum(wx(e_ff) + wx(QUARTER_Q));
               t_in  = t_ff >>> 2;  // w'^2 / 4, non-negative
               st_in = S_T2;
            end
            S_G: begin
               g_in  = sat_sum(wx(t1_ff) - wx(t_ff) + wx(wpp_ff >>> 1));
               st_in = S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_tvalid_in = 1'b1;
                  rsp_tlast_in  = last_ff;
                  rsp_tuser_in  = last_ff && summary.free;
                  rsp_tdata_in  = {last_ff ? summary.point : {DATA_WIDTH{1'b0}},
                                   last_ff ? summary.worst : {DATA_WIDTH{1'b0}},
                                   g_out, clamp_out(wpp_ff), clamp_out(wp_ff),
                                   clamp_out(w_ff)};
                  st_in = S_IDLE;
               end
            end
            default: st_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         wait_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         a_ff          <= '0;
         b_ff          <= SLOPE_B_RESET;
         rho_ff        <= '0;
         m_ff          <= '0;
         sig_ff        <= SIGMA_RESET;
         tol_ff        <= '0;
      end else begin
         st_ff         <= st_in;
         wait_ff       <= wait_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_LEVEL_A:   a_ff   <= csr_data;
               REG_SLOPE_B:   b_ff   <= csr_data[DATA_WIDTH-2:0];
               REG_SKEW_RHO:  rho_ff <= csr_data[RHO_W-1:0];
               REG_SHIFT_M:   m_ff   <= csr_data;
               REG_SIGMA:     sig_ff <= csr_data[DATA_WIDTH-2:0];
               REG_TOLERANCE: tol_ff <= csr_data[DATA_WIDTH-2:0];
               default: ;
            endcase
         end
      end
      k_ff         <= k_in;
      last_ff      <= last_in;
      x_ff         <= x_in;
      px_ff        <= px_in;
      s_ff         <= s_in;
      t_ff         <= t_in;
      t1_ff        <= t1_in;
      e_ff         <= e_in;
      w_ff         <= w_in;
      wp_ff        <= wp_in;
      wpp_ff       <= wpp_in;
      g_ff         <= g_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   svb_mdu u_mdu (
      .clock   (clock),
      .reset   (reset),
      .mdu_req (mdu_req),
      .mdu_rsp (mdu_rsp)
   );

   svb_sweep u_sweep (
      .clock   (clock),
      .reset   (reset),
      .upd     (out_load),
      .last    (last_ff),
      .gq      (g_out),
      .kpt     (k_ff),
      .tol     (tol_ff),
      .summary (summary)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
